// ===== hw/rtl/hsv_to_rgb_percent_macros.svh =====
// Assertion macros for the hsv_to_rgb_percent block.
`ifndef HSV_TO_RGB_PERCENT_MACROS_SVH
`define HSV_TO_RGB_PERCENT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define HSVRGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsv_to_rgb_percent assertion failed");
// Checked at every edge, reset included.
`define HSVRGB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hsv_to_rgb_percent assertion failed");
`else
`define HSVRGB_ASSERT(lbl, prop)
`define HSVRGB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/hsvrgb_pkg.sv =====
// Shared constants, types and scaling helpers for the HSV to RGB converter.
`default_nettype none
package hsvrgb_pkg;

  localparam int unsigned NUM_STAGES = 4;

  localparam logic [8:0] HUE_FULL   = 9'd360;
  localparam logic [8:0] SECTOR_DEG = 9'd60;
  localparam logic [6:0] PERCENT    = 7'd100;
  localparam logic [7:0] CHAN_MAX   = 8'd255;

  // floor(x/100) = (x * RECIP100) >> RECIP100_SH, exact for x <= 25500
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int unsigned RECIP100_SH = 19;
  // floor(x/400) = (x * RECIP400) >> RECIP400_SH, exact for x <= 102000
  localparam logic [17:0] RECIP400    = 18'd167773;
  localparam int unsigned RECIP400_SH = 26;

  typedef enum logic [2:0] {
    SEC_0,  // red to yellow
    SEC_1,  // yellow to green
    SEC_2,  // green to cyan
    SEC_3,  // cyan to blue
    SEC_4,  // blue to magenta
    SEC_5   // magenta to red
  } sector_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;  // per-stage register enable
  } stage_ctrl_t;

  // floor(x/100) for x <= 25500; the product holds 28 bits
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'(RECIP100);
    return prod[RECIP100_SH +: 8];
  endfunction

  // floor(255*n/6000) = floor(17*n/400) for n <= 6000
  function automatic logic [7:0] scale_sixtieths(input logic [12:0] n);
    logic [16:0] n17;
    logic [34:0] prod;
    n17  = (17'(n) << 4) + 17'(n);
    prod = 35'(n17) * 35'(RECIP400);
    return prod[RECIP400_SH +: 8];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hsvrgb_pipe.sv =====
// Four-stage arithmetic datapath of the HSV to RGB converter.
`default_nettype none
module hsvrgb_pipe
  import hsvrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire stage_ctrl_t ctrl,
  input  wire logic [8:0]  hue,
  input  wire logic [6:0]  saturation,
  input  wire logic [6:0]  brightness,
  input  wire logic        mirror_hue,
  output logic      [7:0]  red,
  output logic      [7:0]  green,
  output logic      [7:0]  blue
);

  // ---- stage 1: clamp, mirror, sector split, (100-S)*V and 255*V
  logic [8:0]  h_clamp, h_eff;
  logic [6:0]  s_clamp, v_clamp;
  sector_t     sec_nxt;
  logic [5:0]  f_nxt;
  logic [13:0] p_nxt;
  logic [14:0] cvn_nxt;

  sector_t     s1_sec_r;
  logic [5:0]  s1_f_r;
  logic [6:0]  s1_v_r;
  logic [13:0] s1_p_r;
  logic [14:0] s1_cvn_r;

  always_comb begin
    h_clamp = (hue > HUE_FULL) ? HUE_FULL : hue;
    s_clamp = (saturation > PERCENT) ? PERCENT : saturation;
    v_clamp = (brightness > PERCENT) ? PERCENT : brightness;
    h_eff   = mirror_hue ? (HUE_FULL - h_clamp) : h_clamp;
    // full circle wraps to sector 0
    if (h_eff >= HUE_FULL) begin
      sec_nxt = SEC_0;
      f_nxt   = 6'd0;
    end else if (h_eff >= 9'd300) begin
      sec_nxt = SEC_5;
      f_nxt   = 6'(h_eff - 9'd300);
    end else if (h_eff >= 9'd240) begin
      sec_nxt = SEC_4;
      f_nxt   = 6'(h_eff - 9'd240);
    end else if (h_eff >= 9'd180) begin
      sec_nxt = SEC_3;
      f_nxt   = 6'(h_eff - 9'd180);
    end else if (h_eff >= 9'd120) begin
      sec_nxt = SEC_2;
      f_nxt   = 6'(h_eff - 9'd120);
    end else if (h_eff >= SECTOR_DEG) begin
      sec_nxt = SEC_1;
      f_nxt   = 6'(h_eff - SECTOR_DEG);
    end else begin
      sec_nxt = SEC_0;
      f_nxt   = h_eff[5:0];
    end
    p_nxt   = 14'(PERCENT - s_clamp) * 14'(v_clamp);
    cvn_nxt = 15'(CHAN_MAX) * 15'(v_clamp);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_sec_r <= sec_nxt;
      s1_f_r   <= f_nxt;
      s1_v_r   <= v_clamp;
      s1_p_r   <= p_nxt;
      s1_cvn_r <= cvn_nxt;
    end
  end

  // ---- stage 2: divide by 100 via reciprocal
  logic [7:0] vmin_full;
  sector_t    s2_sec_r;
  logic [5:0] s2_f_r;
  logic [6:0] s2_v_r;
  logic [6:0] s2_vmin_r;
  logic [7:0] s2_cv_r;

  assign vmin_full = div100(15'(s1_p_r));

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_sec_r  <= s1_sec_r;
      s2_f_r    <= s1_f_r;
      s2_v_r    <= s1_v_r;
      s2_vmin_r <= vmin_full[6:0];
      s2_cv_r   <= div100(s1_cvn_r);
    end
  end

  // ---- stage 3: d*f and the rise/fall numerators in sixtieths
  logic [6:0]  d;
  logic [12:0] df;
  sector_t     s3_sec_r;
  logic [7:0]  s3_cv_r;
  logic [14:0] s3_cminn_r;
  logic [12:0] s3_rise_r;
  logic [12:0] s3_fall_r;

  always_comb begin
    d  = s2_v_r - s2_vmin_r;
    df = 13'(d) * 13'(s2_f_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_sec_r   <= s2_sec_r;
      s3_cv_r    <= s2_cv_r;
      s3_cminn_r <= 15'(CHAN_MAX) * 15'(s2_vmin_r);
      s3_rise_r  <= 13'(SECTOR_DEG) * 13'(s2_vmin_r) + df;
      s3_fall_r  <= 13'(SECTOR_DEG) * 13'(s2_v_r) - df;
    end
  end

  // ---- stage 4: final scaling and channel routing
  logic [7:0] cmin, crise, cfall;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] red_r, green_r, blue_r;

  always_comb begin
    cmin  = div100(s3_cminn_r);
    crise = scale_sixtieths(s3_rise_r);
    cfall = scale_sixtieths(s3_fall_r);
    case (s3_sec_r)
      SEC_0: begin
        red_nxt = s3_cv_r; green_nxt = crise;   blue_nxt = cmin;
      end
      SEC_1: begin
        red_nxt = cfall;   green_nxt = s3_cv_r; blue_nxt = cmin;
      end
      SEC_2: begin
        red_nxt = cmin;    green_nxt = s3_cv_r; blue_nxt = crise;
      end
      SEC_3: begin
        red_nxt = cmin;    green_nxt = cfall;   blue_nxt = s3_cv_r;
      end
      SEC_4: begin
        red_nxt = crise;   green_nxt = cmin;    blue_nxt = s3_cv_r;
      end
      default: begin
        red_nxt = s3_cv_r; green_nxt = cmin;    blue_nxt = cfall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_percent.sv =====
// Top level of the HSV (degrees, percent) to 8-bit RGB converter.
// Usage:
//   Input channel in_valid/in_stall carries hue (0..360 degrees),
//   saturation and brightness (0..100 percent) and mirror_hue. Values
//   above range are clamped; mirror_hue maps hue to 360 - hue.
//   Output channel out_valid/out_stall carries red, green, blue.
//   A transfer happens on a rising edge with valid high and stall low.
// Throughput: one color per clock; a new input is taken every cycle
//   while the output side keeps taking results.
// Path: an input passes through the four register stages (clamp/sector,
//   divide by 100, d*f products, final scale and channel routing)
//   before out_valid rises with its result.
// Stall: each stage holds while the one after it is full and blocked,
//   so bubbles are squeezed out; in_stall rises only when all four
//   stages hold data and out_stall is high. The held result does not
//   change while stalled.
// Reset: rst_n is synchronous, active low; it empties the pipeline
//   (all stage valid bits cleared). No state survives between colors.
`default_nettype none
`include "hsv_to_rgb_percent_macros.svh"
module hsv_to_rgb_percent
  import hsvrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [8:0]  in_hue,
  input  wire logic [6:0]  in_saturation,
  input  wire logic [6:0]  in_brightness,
  input  wire logic        in_mirror_hue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue
);

  // Valid bit per stage; index 0 is the first stage.
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  // A stage may load when it is empty or its contents move on.
  logic [NUM_STAGES-1:0] ready;
  stage_ctrl_t           ctrl;

  always_comb begin
    ready[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !vld_r[k] || ready[k+1];
    end
    ctrl.load = ready;
    vld_nxt   = vld_r;
    if (ready[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  hsvrgb_pipe u_pipe (
    .clk        (clk),
    .ctrl       (ctrl),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .mirror_hue (in_mirror_hue),
    .red        (out_red),
    .green      (out_green),
    .blue       (out_blue)
  );

  // Back-pressure reaches the input only with every stage occupied.
  `HSVRGB_ASSERT(a_stall_only_full, in_stall |-> (&vld_r))
  // A taken result with an empty stage behind it leaves a bubble.
  `HSVRGB_ASSERT(a_bubble_moves, (out_valid && !out_stall && !vld_r[NUM_STAGES-2]) |=> !out_valid)
  // Reset empties the whole pipeline.
  `HSVRGB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (vld_r == '0))

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the hsv_to_rgb_percent color converter.
`default_nettype none

import hsvrgb_pkg::*;

// One expected output pixel.
typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} rgb_t;

// Holds the predicted pixels in transfer order and checks the converter output against them.
class color_scoreboard;
  localparam int unsigned NUM_SECTORS = 6;

  rgb_t        pending[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Exact integer version of the HSV to RGB conversion.
  function rgb_t convert_hsv(input logic [8:0] hue, input logic [6:0] sat,
                             input logic [6:0] bri, input logic mirror);
    int unsigned h, s, v, f, vmin, d, df;
    int unsigned lvl_v, lvl_min, lvl_rise, lvl_fall;
    sector_t     sec;
    rgb_t        px;
    h = hue;
    s = sat;
    v = bri;
    // Clamping happens before the mirror.
    if (h > HUE_FULL) h = HUE_FULL;
    if (s > PERCENT) s = PERCENT;
    if (v > PERCENT) v = PERCENT;
    if (mirror) h = HUE_FULL - h;
    // A hue of 360 lands in sector 0 with fraction 0, like hue 0.
    sec  = sector_t'((h / SECTOR_DEG) % NUM_SECTORS);
    f    = h % SECTOR_DEG;
    vmin = ((PERCENT - s) * v) / PERCENT;
    d    = v - vmin;
    df   = d * f;
    lvl_v    = (CHAN_MAX * v) / PERCENT;
    lvl_min  = (CHAN_MAX * vmin) / PERCENT;
    lvl_rise = (CHAN_MAX * (SECTOR_DEG * vmin + df)) / (PERCENT * SECTOR_DEG);
    lvl_fall = (CHAN_MAX * (SECTOR_DEG * v - df)) / (PERCENT * SECTOR_DEG);
    case (sec)
      SEC_0:   px = '{lvl_v[7:0],    lvl_rise[7:0], lvl_min[7:0]};
      SEC_1:   px = '{lvl_fall[7:0], lvl_v[7:0],    lvl_min[7:0]};
      SEC_2:   px = '{lvl_min[7:0],  lvl_v[7:0],    lvl_rise[7:0]};
      SEC_3:   px = '{lvl_min[7:0],  lvl_fall[7:0], lvl_v[7:0]};
      SEC_4:   px = '{lvl_rise[7:0], lvl_min[7:0],  lvl_v[7:0]};
      default: px = '{lvl_v[7:0],    lvl_min[7:0],  lvl_fall[7:0]};
    endcase
    return px;
  endfunction

  function void note_color(input logic [8:0] hue, input logic [6:0] sat,
                           input logic [6:0] bri, input logic mirror);
    pending.push_back(convert_hsv(hue, sat, bri, mirror));
  endfunction

  function void compare_channel(input string name, input logic [7:0] want,
                                input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rgb_t want;
    if (pending.size() == 0) begin
      $error("unexpected pixel r=%0d g=%0d b=%0d", r, g, b);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    compare_channel("red", want.red, r);
    compare_channel("green", want.green, g);
    compare_channel("blue", want.blue, b);
  endfunction
endclass

module testbench;
  // Hold-off length for the back-pressure test and the no-progress limit.
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned ITEMS_PHASE  = 630;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [8:0] in_hue = '0;
  logic [6:0] in_saturation = '0;
  logic [6:0] in_brightness = '0;
  logic       in_mirror_hue = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // Idle odds in percent, set by the stimulus thread per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long hold-off handshake: stimulus bumps the request count, the receiver
  // notices the difference and runs the hold-off on its own counter.
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  int unsigned quiet_cycles = 0;

  color_scoreboard sb = new();

  always #5 clk = ~clk;

  hsv_to_rgb_percent dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .in_mirror_hue(in_mirror_hue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  // Input transfers feed the predictor, output transfers are checked.
  // Sampling in the active region of the edge sees pre-edge values on both sides.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_color(in_hue, in_saturation, in_brightness, in_mirror_hue);
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel(out_red, out_green, out_blue);
  end

  // Receiver: random stall, or a long solid hold-off when one is requested.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD - 1;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one color; returns right after the edge at which it transferred.
  // Idle cycles go out first, with junk on the payload and valid low.
  task automatic send_color(input logic [8:0] h, input logic [6:0] s,
                            input logic [6:0] v, input logic m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      in_hue        <= 9'($urandom);
      in_saturation <= 7'($urandom);
      in_brightness <= 7'($urandom);
      in_mirror_hue <= 1'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    in_mirror_hue <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly in-range colors, with sector edges and out-of-range values mixed in.
  task automatic send_random_color();
    logic [8:0] h;
    logic [6:0] s;
    logic [6:0] v;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)      h = 9'($urandom_range(511));
    else if (pick == 1) h = 9'(60 * $urandom_range(6));
    else                h = 9'($urandom_range(360));
    pick = $urandom_range(9);
    if (pick == 0)      s = 7'($urandom_range(127));
    else if (pick == 1) s = ($urandom_range(1)) ? 7'd100 : 7'd0;
    else                s = 7'($urandom_range(100));
    pick = $urandom_range(9);
    if (pick == 0)      v = 7'($urandom_range(127));
    else if (pick == 1) v = ($urandom_range(1)) ? 7'd100 : 7'd0;
    else                v = 7'($urandom_range(100));
    send_color(h, s, v, 1'($urandom));
  endtask

  initial begin
    int unsigned k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles rarely, receiver often.
    send_idle_pct = 11;
    recv_idle_pct = 57;

    // Directed colors: field extremes, every sector, clamping and the mirror.
    send_color(9'd0,   7'd100, 7'd100, 1'b0);  // pure red
    send_color(9'd60,  7'd100, 7'd100, 1'b0);
    send_color(9'd120, 7'd100, 7'd100, 1'b0);
    send_color(9'd180, 7'd100, 7'd100, 1'b0);
    send_color(9'd240, 7'd100, 7'd100, 1'b0);
    send_color(9'd300, 7'd100, 7'd100, 1'b0);
    send_color(9'd359, 7'd100, 7'd100, 1'b0);
    send_color(9'd360, 7'd100, 7'd100, 1'b0);  // wraps to sector 0
    send_color(9'd361, 7'd80,  7'd90,  1'b0);  // hue clamps to 360
    send_color(9'd511, 7'd127, 7'd127, 1'b0);  // everything clamps
    send_color(9'd511, 7'd50,  7'd100, 1'b1);  // clamp, then mirror to 0
    send_color(9'd0,   7'd100, 7'd100, 1'b1);  // mirror to 360
    send_color(9'd30,  7'd100, 7'd100, 1'b1);  // mirror to 330
    send_color(9'd359, 7'd100, 7'd100, 1'b1);
    send_color(9'd59,  7'd100, 7'd100, 1'b0);
    send_color(9'd90,  7'd0,   7'd100, 1'b0);  // gray
    send_color(9'd200, 7'd100, 7'd0,   1'b0);  // black
    send_color(9'd200, 7'd101, 7'd101, 1'b0);
    send_color(9'd150, 7'd127, 7'd64,  1'b1);
    send_color(9'd270, 7'd37,  7'd127, 1'b0);
    send_color(9'd45,  7'd1,   7'd1,   1'b0);
    send_color(9'd256, 7'd99,  7'd99,  1'b1);

    for (k = 0; k < ITEMS_PHASE; k++) send_random_color();

    // Phase two: roles swapped.
    send_idle_pct = 57;
    recv_idle_pct = 11;
    for (k = 0; k < ITEMS_PHASE; k++) send_random_color();

    // Phase three: full rate on both sides, with one long receiver hold-off
    // partway through so the pipeline fills and in_stall has to rise.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < ITEMS_PHASE; k++) begin
      if (k == ITEMS_PHASE / 2) hold_requests = hold_requests + 1;
      send_random_color();
    end
    in_valid <= 1'b0;

    // Drain, then a few extra cycles to catch any stray pixel.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
